// File: rtl/core/linear_congruence_solver_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear congruence solver
// Shared property wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`define LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define LCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define LCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define LCS_ASSERT_IMP(lbl, ante, cons, msg)
`define LCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/lcs_pkg.sv
// ----------------------------------------------------------------------------
// Linear congruence solver package
// Shared constants.
// ----------------------------------------------------------------------------
package lcs_pkg;
	localparam int MOD_BITS_DEF  = 16;
	localparam int COEF_BITS_DEF = 24;
	localparam int MOD_RESET     = 768;
endpackage

// File: rtl/core/lcs_divider.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle; unsigned numerator and divisor.
// ----------------------------------------------------------------------------
module lcs_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// File: rtl/core/linear_congruence_solver.sv
// ----------------------------------------------------------------------------
// Linear congruence solver
// Solves A*x = B (mod M) with one shared divider under a sequencer.
// ----------------------------------------------------------------------------
// One word in gives one word out. A and B are reduced mod M, g = gcd(A, M)
// is found by Euclid, B is checked against g, then A/g, B/g, M/g are formed
// and the inverse of A/g is found by extended Euclid, and x0 = inv*(B/g)
// mod (M/g). Every division (residues, each Euclid step, the final product)
// runs on one restoring divider of max(COEF_BITS, 2*MOD_BITS) bits, one
// quotient bit per cycle, and each result word leaves through an output
// register; how many divisions an item needs is set by the Euclid step
// counts. A zero modulus skips the divider and goes from accept straight
// to the output state, where its all-zero word is registered.
// s_axis_tready is high only when the block is idle and no result waits.
// Unsolvable items give all zeros.
`include "linear_congruence_solver_defines.svh"

module linear_congruence_solver #(
	parameter int MOD_BITS  = lcs_pkg::MOD_BITS_DEF,
	parameter int COEF_BITS = lcs_pkg::COEF_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [MOD_BITS-1:0]  cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// coef_a, coef_b
	input  logic [((2*COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// has_solution, base_solution, spacing, solution_count
	output logic [((3*MOD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);
	import lcs_pkg::*;

	localparam int OW = (3*MOD_BITS+1+7)/8*8;
	localparam int XW = (COEF_BITS > MOD_BITS) ? COEF_BITS : MOD_BITS;
	// wide enough for inv*bp products
	localparam int DW = (XW > 2*MOD_BITS) ? XW : 2*MOD_BITS;
	localparam int SW = MOD_BITS + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RA, ST_RB, ST_GCD, ST_CHK, ST_DA, ST_DB, ST_DM,
		ST_EU, ST_MUL, ST_OUT
	} state_t;

	state_t              state_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [COEF_BITS-1:0] ca_q, cb_q;
	logic [MOD_BITS-1:0] a_q, b_q, g_q, r0_q, r1_q, mp_q, bp_q;
	logic signed [SW-1:0] s0_q, s1_q;
	logic                pend_q;
	logic                dv_start;
	logic                dv_go;
	logic [DW-1:0]       dv_num, dv_den, dv_quo, dv_rem;
	logic                dv_done;
	logic [OW-1:0]       out_q;
	logic                ovalid_q;
	logic [MOD_BITS-1:0] rres;
	logic signed [SW-1:0] snew, sfix;
	logic [2*MOD_BITS-1:0] prod;
	logic [3*MOD_BITS:0] res_word;

	lcs_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(dv_den), .done(dv_done), .quo(dv_quo), .rem(dv_rem)
	);

	// residue of signed coefficient: divide magnitude, then fold the sign
	function automatic logic [DW-1:0] mag(input logic [COEF_BITS-1:0] c);
		logic [COEF_BITS-1:0] n;
		n = c[COEF_BITS-1] ? (~c + 1'b1) : c;
		return DW'(n);
	endfunction

	always_comb begin
		logic [MOD_BITS-1:0] r;
		logic neg;
		r   = dv_rem[MOD_BITS-1:0];
		neg = (state_q == ST_RA) ? ca_q[COEF_BITS-1] : cb_q[COEF_BITS-1];
		rres = (neg && r != '0) ? mod_q - r : r;
	end

	assign snew = s0_q - SW'($signed({1'b0, dv_quo[MOD_BITS-1:0]}) * s1_q);
	assign sfix = s0_q[SW-1] ? s0_q + SW'({2'b0, mp_q}) : s0_q;
	assign prod = MOD_BITS'(sfix) * bp_q;

	// packed result: flag, x0, spacing, count
	assign res_word = pend_q ? {g_q, mp_q, dv_rem[MOD_BITS-1:0], 1'b1} : '0;

	always_comb begin
		dv_num = DW'(r0_q);
		dv_den = DW'(r1_q);
		case (state_q)
			ST_RA:  begin dv_num = mag(ca_q); dv_den = DW'(mod_q); end
			ST_RB:  begin dv_num = mag(cb_q); dv_den = DW'(mod_q); end
			ST_CHK: begin dv_num = DW'(b_q);  dv_den = DW'(g_q);   end
			ST_DA:  begin dv_num = DW'(a_q);  dv_den = DW'(g_q);   end
			ST_DB:  begin dv_num = DW'(b_q);  dv_den = DW'(g_q);   end
			ST_DM:  begin dv_num = DW'(mod_q); dv_den = DW'(g_q);  end
			ST_MUL: begin dv_num = DW'(prod); dv_den = DW'(mp_q);  end
			default: ;
		endcase
	end

	// next divider launch: every step that leads to another division
	always_comb begin
		case (state_q)
			ST_IDLE: dv_go = s_axis_tvalid && s_axis_tready && (mod_q != '0);
			ST_RA, ST_RB, ST_GCD, ST_DA, ST_DB, ST_DM, ST_EU: dv_go = dv_done;
			ST_CHK:  dv_go = dv_done && (dv_rem[MOD_BITS-1:0] == '0);
			default: dv_go = 1'b0;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q    <= MOD_BITS'(MOD_RESET);
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			pend_q   <= 1'b0;
			dv_start <= 1'b0;
		end else begin
			dv_start <= dv_go;
			if (cfg_we) mod_q <= cfg_wdata;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					ca_q <= s_axis_tdata[COEF_BITS-1:0];
					cb_q <= s_axis_tdata[2*COEF_BITS-1:COEF_BITS];
					if (mod_q == '0) begin
						state_q <= ST_OUT;
						pend_q  <= 1'b0;
					end else begin
						state_q  <= ST_RA;
					end
				end
				ST_RA: if (dv_done) begin
					a_q <= rres; state_q <= ST_RB;
				end
				ST_RB: if (dv_done) begin
					b_q <= rres;
					r0_q <= mod_q; r1_q <= a_q;
					if (a_q == '0) begin
						g_q <= mod_q; state_q <= ST_CHK;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: if (dv_done) begin
					if (dv_rem[MOD_BITS-1:0] == '0) begin
						g_q <= r1_q; state_q <= ST_CHK;
					end else begin
						r0_q <= r1_q; r1_q <= dv_rem[MOD_BITS-1:0];
					end
				end
				ST_CHK: if (dv_done) begin
					if (dv_rem[MOD_BITS-1:0] != '0) begin
						pend_q <= 1'b0; state_q <= ST_OUT;
					end else begin
						state_q <= ST_DA;
					end
				end
				ST_DA: if (dv_done) begin
					a_q <= dv_quo[MOD_BITS-1:0]; state_q <= ST_DB;
				end
				ST_DB: if (dv_done) begin
					bp_q <= dv_quo[MOD_BITS-1:0]; state_q <= ST_DM;
				end
				ST_DM: if (dv_done) begin
					mp_q <= dv_quo[MOD_BITS-1:0];
					r0_q <= dv_quo[MOD_BITS-1:0]; r1_q <= a_q;
					s0_q <= '0;
					pend_q <= 1'b1;
					// reduced modulus of one: inverse taken as zero
					if (dv_quo[MOD_BITS-1:0] <= MOD_BITS'(1) || a_q == '0) begin
						s1_q <= '0;
						state_q <= ST_MUL;
					end else begin
						s1_q <= SW'(1);
						state_q <= ST_EU;
					end
				end
				ST_EU: if (dv_done) begin
					r0_q <= r1_q; r1_q <= dv_rem[MOD_BITS-1:0];
					s0_q <= s1_q; s1_q <= snew;
					if (dv_rem[MOD_BITS-1:0] == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: if (dv_done) begin
					state_q <= ST_OUT;
				end
				ST_OUT: if (!ovalid_q) begin
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
					out_q    <= OW'(res_word);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LCS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
	`LCS_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")
	`LCS_ASSERT_IMP(a_base_below_spacing, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[MOD_BITS:1] < m_axis_tdata[2*MOD_BITS:MOD_BITS+1], "base solution not below spacing")
	`LCS_ASSERT_IMP(a_unsolved_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata == '0, "unsolvable word not all zeros")
endmodule
